FILE: rtl/fpfa_pkg.sv
// Shared types, widths and codes of the fixed partition fit allocator.
package fpfa_pkg;

   // Field widths fixed by the channel format
   localparam int REQ_TYPE_BITS   = 2;
   localparam int INDEX_BITS      = 4;
   localparam int FIELD_SIZE_BITS = 16;
   localparam int STATUS_BITS     = 2;
   localparam int WASTE_BITS      = 16;

   // Control register widths
   localparam int POLICY_BITS    = 2;
   localparam int BLOCKS_BITS    = 5;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;

   // Defaults for the top level parameters
   localparam int DEF_MAX_PARTITIONS = 16;
   localparam int DEF_SIZE_BITS      = 16;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BLOCKS_BITS-1:0] BLOCKS_RESET = 5'd16;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_ALLOC = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_GRANT  = 2'd1,
      STATUS_NOFIT  = 2'd2,
      STATUS_BADIDX = 2'd3
   } status_type;

   typedef enum logic [POLICY_BITS-1:0] {
      POLICY_FIRST = 2'd0,
      POLICY_BEST  = 2'd1,
      POLICY_WORST = 2'd2,
      POLICY_NEXT  = 2'd3
   } policy_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POLICY = 1'd0,
      CSR_BLOCKS = 1'd1
   } csr_index_type;

   // Classified command as seen by the back end
   typedef enum logic [2:0] {
      CMD_LOAD   = 3'd0,
      CMD_BADIDX = 3'd1,
      CMD_CLEAR  = 3'd2,
      CMD_ALLOC  = 3'd3,
      CMD_NOP    = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [INDEX_BITS-1:0]      index;
      logic [FIELD_SIZE_BITS-1:0] size;
   } cmd_type;

   typedef struct packed {
      policy_type             policy;
      logic [BLOCKS_BITS-1:0] blocks_in_use;
   } cfg_type;

endpackage

FILE: rtl/fpfa_req_if.sv
// Request channel: valid, ready and the request payload.
interface fpfa_req_if import fpfa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [REQ_TYPE_BITS-1:0]   req_type;
   logic [INDEX_BITS-1:0]      load_index;
   logic [FIELD_SIZE_BITS-1:0] partition_size;
   logic [FIELD_SIZE_BITS-1:0] request_size;

   modport source (output valid, req_type, load_index, partition_size, request_size,
                   input ready);
   modport sink (input valid, req_type, load_index, partition_size, request_size,
                 output ready);
endinterface

FILE: rtl/fpfa_rsp_if.sv
// Response channel: valid, ready and the result payload.
interface fpfa_rsp_if import fpfa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [INDEX_BITS-1:0]  granted_partition;
   logic [WASTE_BITS-1:0]  waste;

   modport source (output valid, status, granted_partition, waste, input ready);
   modport sink (input valid, status, granted_partition, waste, output ready);
endinterface

FILE: rtl/fixed_partition_fit_allocator.sv
// Top level of the fixed partition fit allocator: control registers, front, queue, back.
//
//   channel   direction  beat contents
//   req_ch    in         req_type, load_index, partition_size, request_size
//   rsp_ch    out        status, granted_partition, waste
//   csr_*     in         csr_write_en, csr_index, csr_wdata (policy, blocks_in_use)
//
// Load, clear and no-op requests are answered straight from the idle state; an
// allocate scans n = min(blocks_in_use, MAX_PARTITIONS) entries of the size table
// through its single read port, one partition a cycle.
// Reset clears the used marks, pointer and control state; sizes stay unwritten.
// Front and back stall independently through a two entry command queue.
module fixed_partition_fit_allocator import fpfa_pkg::*; #(
   parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
   parameter int SIZE_BITS      = DEF_SIZE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   fpfa_req_if.sink                  req_ch,
   fpfa_rsp_if.source                rsp_ch
);

   cfg_type cfg_ff, cfg_in;
   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // Control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_POLICY: cfg_in.policy        = policy_type'(csr_wdata[POLICY_BITS-1:0]);
            CSR_BLOCKS: cfg_in.blocks_in_use = csr_wdata[BLOCKS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy        <= POLICY_FIRST;
         cfg_ff.blocks_in_use <= BLOCKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fpfa_front #(
      .MAX_PARTITIONS (MAX_PARTITIONS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   fpfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   fpfa_back #(
      .MAX_PARTITIONS (MAX_PARTITIONS),
      .SIZE_BITS      (SIZE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: rtl/fpfa_ram.sv
// Generic single write port RAM with a registered read port.
module fpfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/fpfa_front.sv
// Front end: accept request beats, classify them and hand them to the queue.
module fpfa_front import fpfa_pkg::*; #(
   parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS
) (
   input  logic          clock,
   input  logic          reset,
   fpfa_req_if.sink      req_ch,
   output logic          push_valid,
   input  logic          push_ready,
   output cmd_type       push_cmd
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   cmd_type class_cmd;
   logic    accept;

   // Classify the incoming beat
   always_comb begin
      class_cmd.index = req_ch.load_index;
      class_cmd.size  = req_ch.request_size;
      unique case (req_ch.req_type)
         REQ_LOAD: begin
            class_cmd.size = req_ch.partition_size;
            if (32'(req_ch.load_index) < 32'(MAX_PARTITIONS)) begin
               class_cmd.kind = CMD_LOAD;
            end else begin
               class_cmd.kind = CMD_BADIDX;
            end
         end
         REQ_CLEAR: class_cmd.kind = CMD_CLEAR;
         REQ_ALLOC: class_cmd.kind = CMD_ALLOC;
         default:   class_cmd.kind = CMD_NOP;
      endcase
   end

   // Hold one classified beat until the queue takes it
   assign req_ch.ready = !hold_valid_ff || push_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (hold_valid_ff && push_ready) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = class_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

endmodule

FILE: rtl/fpfa_queue.sv
// Short command queue between the front and back ends.
module fpfa_queue import fpfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = count_ff != CNTW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/fpfa_back.sv
// Back end: execute commands, scan the size table and drive the response beat.
module fpfa_back import fpfa_pkg::*; #(
   parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
   parameter int SIZE_BITS      = DEF_SIZE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  cmd_type    pop_cmd,
   fpfa_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(MAX_PARTITIONS);
   localparam int CW = $clog2(MAX_PARTITIONS + 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type              state_ff, state_in;
   logic [MAX_PARTITIONS-1:0] used_ff, used_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic [IW-1:0]          issue_idx_ff, issue_idx_in;
   logic [CW-1:0]          issue_cnt_ff, issue_cnt_in;
   logic                   eval_valid_ff, eval_valid_in;
   logic [IW-1:0]          eval_idx_ff, eval_idx_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          pick_ff, pick_in;
   logic [SIZE_BITS-1:0]   pick_size_ff, pick_size_in;
   logic [SIZE_BITS-1:0]   best_ff, best_in;
   logic [SIZE_BITS-1:0]   req_size_ff, req_size_in;
   logic [CW-1:0]          n_ff, n_in;
   logic                   out_valid_ff, out_valid_in;
   status_type             out_status_ff, out_status_in;
   logic [INDEX_BITS-1:0]  out_granted_ff, out_granted_in;
   logic [WASTE_BITS-1:0]  out_waste_ff, out_waste_in;

   logic                   ram_we, ram_re;
   logic [IW-1:0]          ram_waddr, ram_raddr;
   logic [SIZE_BITS-1:0]   ram_wdata, ram_rdata;

   logic [CW-1:0]          n_active;
   logic                   out_free;
   logic                   fit, take;
   logic [SIZE_BITS-1:0]   slack;

   fpfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (MAX_PARTITIONS)
   ) u_size_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Number of partitions taking part in a search
   always_comb begin
      if (32'(cfg.blocks_in_use) < 32'(MAX_PARTITIONS)) begin
         n_active = CW'(cfg.blocks_in_use);
      end else begin
         n_active = CW'(MAX_PARTITIONS);
      end
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // Judge the entry read in the previous cycle
   assign fit   = !used_ff[eval_idx_ff] && (ram_rdata >= req_size_ff);
   assign slack = ram_rdata - req_size_ff;
   assign take  = eval_valid_ff && fit &&
                  (!found_ff ||
                   (cfg.policy == POLICY_BEST && slack < best_ff) ||
                   (cfg.policy == POLICY_WORST && slack > best_ff));

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      ptr_in         = ptr_ff;
      issue_idx_in   = issue_idx_ff;
      issue_cnt_in   = issue_cnt_ff;
      eval_valid_in  = eval_valid_ff;
      eval_idx_in    = eval_idx_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      pick_size_in   = pick_size_ff;
      best_in        = best_ff;
      req_size_in    = req_size_ff;
      n_in           = n_ff;
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_granted_in = out_granted_ff;
      out_waste_in   = out_waste_ff;
      pop_ready      = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = IW'(pop_cmd.index);
      ram_wdata      = SIZE_BITS'(pop_cmd.size);
      ram_re         = 1'b0;
      ram_raddr      = issue_idx_ff;

      // Drop a response beat once taken
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready      = 1'b1;
               out_valid_in   = 1'b1;
               out_status_in  = STATUS_DONE;
               out_granted_in = '0;
               out_waste_in   = '0;
               unique case (pop_cmd.kind)
                  CMD_LOAD: begin
                     ram_we = 1'b1;
                  end
                  CMD_BADIDX: begin
                     out_status_in = STATUS_BADIDX;
                  end
                  CMD_CLEAR: begin
                     used_in = '0;
                     ptr_in  = '0;
                  end
                  CMD_ALLOC: begin
                     if (n_active == '0) begin
                        out_status_in = STATUS_NOFIT;
                     end else begin
                        // Start the scan; the result comes at its end
                        out_valid_in  = 1'b0;
                        req_size_in   = SIZE_BITS'(pop_cmd.size);
                        n_in          = n_active;
                        issue_cnt_in  = '0;
                        eval_valid_in = 1'b0;
                        found_in      = 1'b0;
                        if (cfg.policy == POLICY_NEXT && CW'(ptr_ff) < n_active) begin
                           issue_idx_in = ptr_ff;
                        end else begin
                           issue_idx_in = '0;
                        end
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue one table read a cycle, circularly from the start index
            if (issue_cnt_ff != n_ff) begin
               ram_re        = 1'b1;
               eval_valid_in = 1'b1;
               eval_idx_in   = issue_idx_ff;
               issue_cnt_in  = issue_cnt_ff + CW'(1);
               if (CW'(issue_idx_ff) + CW'(1) == n_ff) begin
                  issue_idx_in = '0;
               end else begin
                  issue_idx_in = issue_idx_ff + IW'(1);
               end
            end else begin
               eval_valid_in = 1'b0;
            end

            // Keep the best candidate so far
            if (take) begin
               found_in     = 1'b1;
               pick_in      = eval_idx_ff;
               pick_size_in = ram_rdata;
               best_in      = slack;
            end

            // Finish once every read has been judged
            if (issue_cnt_ff == n_ff && !eval_valid_ff) begin
               state_in       = S_IDLE;
               out_valid_in   = 1'b1;
               out_granted_in = '0;
               out_waste_in   = '0;
               if (found_ff) begin
                  used_in[pick_ff] = 1'b1;
                  if (cfg.policy == POLICY_NEXT) begin
                     if (CW'(pick_ff) + CW'(1) == n_ff) begin
                        ptr_in = '0;
                     end else begin
                        ptr_in = pick_ff + IW'(1);
                     end
                  end
                  out_status_in  = STATUS_GRANT;
                  out_granted_in = INDEX_BITS'(pick_ff);
                  out_waste_in   = WASTE_BITS'(pick_size_ff - req_size_ff);
               end else begin
                  out_status_in = STATUS_NOFIT;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         ptr_ff        <= '0;
         eval_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         ptr_ff        <= ptr_in;
         eval_valid_ff <= eval_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      issue_idx_ff   <= issue_idx_in;
      issue_cnt_ff   <= issue_cnt_in;
      eval_idx_ff    <= eval_idx_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      pick_size_ff   <= pick_size_in;
      best_ff        <= best_in;
      req_size_ff    <= req_size_in;
      n_ff           <= n_in;
      out_status_ff  <= out_status_in;
      out_granted_ff <= out_granted_in;
      out_waste_ff   <= out_waste_in;
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.status            = out_status_ff;
   assign rsp_ch.granted_partition = out_granted_ff;
   assign rsp_ch.waste             = out_waste_ff;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fixed partition fit allocator: table, then random phases.
module testbench;
   import fpfa_pkg::*;

   localparam int PARTS           = DEF_MAX_PARTITIONS;
   localparam int HOLDOFF_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASES          = 14;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int PAUSE_PHASE     = 6;
   localparam int HOLDOFF_PHASE   = 1;

   // Request type with no operation behind it
   localparam logic [REQ_TYPE_BITS-1:0] REQ_NOP = 2'd3;

   typedef struct packed {
      status_type                 status;
      logic [INDEX_BITS-1:0]      part;
      logic [WASTE_BITS-1:0]      waste;
   } alloc_rsp_type;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0]   kind;
      logic [INDEX_BITS-1:0]      index;
      logic [FIELD_SIZE_BITS-1:0] psize;
      logic [FIELD_SIZE_BITS-1:0] rsize;
      logic                       typed;
      alloc_rsp_type              rsp;
   } stim_row_type;

   // Directed beats under the reset setting (first fit, all sixteen partitions)
   localparam stim_row_type DIRECTED [25] = '{
      '{REQ_CLEAR, 4'd0,  16'd0,     16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_NOP,   4'd15, 16'hffff,  16'hffff,  1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd0,  16'hffff,  16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd1,  16'd0,     16'hffff,  1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd2,  16'd100,   16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd3,  16'd300,   16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd4,  16'd200,   16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd5,  16'd1000,  16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd6,  16'd50,    16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd7,  16'd300,   16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd8,  16'd200,   16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd9,  16'd4000,  16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd10, 16'd12,    16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd11, 16'd999,   16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd12, 16'd300,   16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd13, 16'd2048,  16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd14, 16'd7,     16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_LOAD,  4'd15, 16'hffff,  16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_ALLOC, 4'd0,  16'd0,     16'd0,     1'b1, '{STATUS_GRANT, 4'd0,  16'hffff}},
      '{REQ_ALLOC, 4'd0,  16'd0,     16'hffff,  1'b1, '{STATUS_GRANT, 4'd15, 16'd0}},
      '{REQ_ALLOC, 4'd0,  16'd0,     16'hffff,  1'b1, '{STATUS_NOFIT, 4'd0,  16'd0}},
      '{REQ_ALLOC, 4'd0,  16'd0,     16'd250,   1'b0, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_ALLOC, 4'd0,  16'd0,     16'd300,   1'b0, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_ALLOC, 4'd0,  16'd0,     16'd1,     1'b0, '{STATUS_DONE,  4'd0,  16'd0}},
      '{REQ_CLEAR, 4'd0,  16'd0,     16'd0,     1'b1, '{STATUS_DONE,  4'd0,  16'd0}}
   };

   // Settings walked by the random phases, extremes included
   localparam policy_type PHASE_POLICY [PHASES] = '{
      POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_NEXT, POLICY_NEXT, POLICY_BEST,
      POLICY_WORST, POLICY_FIRST, POLICY_NEXT, POLICY_BEST, POLICY_WORST, POLICY_NEXT,
      POLICY_FIRST, POLICY_BEST
   };
   localparam logic [BLOCKS_BITS-1:0] PHASE_BLOCKS [PHASES] = '{
      5'd16, 5'd16, 5'd16, 5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd1, 5'd7, 5'd3, 5'd17,
      5'd9, 5'd2
   };

   logic clock = 1'b0;
   logic reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   fpfa_req_if req_bus ();
   fpfa_rsp_if rsp_bus ();

   fixed_partition_fit_allocator u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_ch       (req_bus),
      .rsp_ch       (rsp_bus)
   );

   always #1 clock = ~clock;

   // Mirror of the allocator state and settings
   logic [FIELD_SIZE_BITS-1:0] part_size [PARTS];
   bit                         part_used [PARTS];
   int                         next_ptr;
   policy_type                 cur_policy;
   logic [BLOCKS_BITS-1:0]     cur_blocks;

   alloc_rsp_type awaited_responses [$];
   int            mismatch_count = 0;
   int            burst_left     = 0;
   int            holdoff_asked  = 0;
   int            quiet_cycles   = 0;

   // Apply one beat to the mirror and return the response it must produce
   function automatic alloc_rsp_type place_request(logic [REQ_TYPE_BITS-1:0] kind,
                                                   logic [INDEX_BITS-1:0] index,
                                                   logic [FIELD_SIZE_BITS-1:0] psize,
                                                   logic [FIELD_SIZE_BITS-1:0] rsize);
      int                         n;
      int                         idx;
      int                         pick;
      logic [FIELD_SIZE_BITS-1:0] best;
      logic [FIELD_SIZE_BITS-1:0] w;
      alloc_rsp_type              r;
      r = '{STATUS_DONE, '0, '0};
      case (kind)
         REQ_LOAD: begin
            part_size[index] = psize;
         end
         REQ_CLEAR: begin
            for (int i = 0; i < PARTS; i++) part_used[i] = 1'b0;
            next_ptr = 0;
         end
         REQ_ALLOC: begin
            n    = (cur_blocks > PARTS) ? PARTS : int'(cur_blocks);
            pick = -1;
            best = '0;
            if (cur_policy == POLICY_NEXT) begin
               // circular scan from the pointer, a stale pointer restarts at zero
               idx = (next_ptr < n) ? next_ptr : 0;
               for (int k = 0; k < n; k++) begin
                  if (pick < 0 && !part_used[idx] && part_size[idx] >= rsize) pick = idx;
                  idx = (idx + 1 == n) ? 0 : idx + 1;
               end
            end else begin
               // lowest index wins ties; first fit keeps the first hit
               for (int k = 0; k < n; k++) begin
                  if (!part_used[k] && part_size[k] >= rsize) begin
                     w = part_size[k] - rsize;
                     if (pick < 0 || (cur_policy == POLICY_BEST && w < best) ||
                         (cur_policy == POLICY_WORST && w > best)) begin
                        pick = k;
                        best = w;
                     end
                  end
               end
            end
            if (pick < 0) begin
               r.status = STATUS_NOFIT;
            end else begin
               part_used[pick] = 1'b1;
               if (cur_policy == POLICY_NEXT) next_ptr = (pick + 1 == n) ? 0 : pick + 1;
               r.status = STATUS_GRANT;
               r.part   = INDEX_BITS'(pick);
               r.waste  = part_size[pick] - rsize;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Draw a random beat: mostly allocations sized near a loaded partition
   task automatic draw_request(output logic [REQ_TYPE_BITS-1:0] kind,
                               output logic [INDEX_BITS-1:0] index,
                               output logic [FIELD_SIZE_BITS-1:0] psize,
                               output logic [FIELD_SIZE_BITS-1:0] rsize);
      int roll;
      int sel;
      int k;
      int sub;
      kind  = REQ_ALLOC;
      index = INDEX_BITS'($urandom);
      psize = FIELD_SIZE_BITS'($urandom);
      rsize = FIELD_SIZE_BITS'($urandom);
      roll  = $urandom_range(0, 99);
      if (roll < 9) begin
         kind = REQ_LOAD;
         sel  = $urandom_range(0, 9);
         if (sel < 3) psize = FIELD_SIZE_BITS'($urandom_range(0, 2047));
         else if (sel < 6) psize = FIELD_SIZE_BITS'(256 << $urandom_range(0, 2));
         else if (sel == 6) psize = '0;
         else if (sel == 7) psize = '1;
      end else if (roll < 16) begin
         kind = REQ_CLEAR;
      end else if (roll < 19) begin
         kind = REQ_NOP;
      end else begin
         sel = $urandom_range(0, 19);
         if (sel < 11) begin
            k     = $urandom_range(0, PARTS - 1);
            sub   = $urandom_range(0, 255);
            rsize = (part_size[k] > sub) ? part_size[k] - FIELD_SIZE_BITS'(sub) : '0;
         end else if (sel < 15) begin
            rsize = rsize;
         end else if (sel < 17) begin
            rsize = FIELD_SIZE_BITS'($urandom_range(0, 2047));
         end else if (sel < 19) begin
            rsize = '0;
         end else begin
            rsize = '1;
         end
      end
   endtask

   // Offer one beat, opening a gap between bursts, and hold until accepted
   task automatic offer_beat(input stim_row_type row);
      alloc_rsp_type predicted;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 16);
      end
      req_bus.valid          <= 1'b1;
      req_bus.req_type       <= row.kind;
      req_bus.load_index     <= row.index;
      req_bus.partition_size <= row.psize;
      req_bus.request_size   <= row.rsize;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      // The mirror follows every beat, typed rows included
      predicted = place_request(row.kind, row.index, row.psize, row.rsize);
      awaited_responses.push_back(row.typed ? row.rsp : predicted);
   endtask

   // Drop valid and wait for every awaited response
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (awaited_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(input policy_type pol, input logic [BLOCKS_BITS-1:0] blocks);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_POLICY;
      csr_wdata    <= {3'($urandom), pol};
      @(posedge clock);
      cur_policy = pol;
      csr_index  <= CSR_BLOCKS;
      csr_wdata  <= blocks;
      @(posedge clock);
      cur_blocks = blocks;
      csr_write_en <= 1'b0;
   endtask

   // Stimulus
   initial begin
      stim_row_type row;
      reset                  <= 1'b1;
      csr_write_en           <= 1'b0;
      csr_index              <= CSR_POLICY;
      csr_wdata              <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.req_type       <= REQ_LOAD;
      req_bus.load_index     <= '0;
      req_bus.partition_size <= '0;
      req_bus.request_size   <= '0;
      cur_policy = POLICY_FIRST;
      cur_blocks = BLOCKS_RESET;
      next_ptr   = 0;
      for (int i = 0; i < PARTS; i++) begin
         part_size[i] = '0;
         part_used[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) offer_beat(DIRECTED[i]);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         write_config(PHASE_POLICY[ph], PHASE_BLOCKS[ph]);
         if (ph == HOLDOFF_PHASE) holdoff_asked++;
         for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
            if (ph == PAUSE_PHASE && it == ITEMS_PER_PHASE / 2) settle();
            draw_request(row.kind, row.index, row.psize, row.rsize);
            row.typed = 1'b0;
            row.rsp   = '{STATUS_DONE, '0, '0};
            offer_beat(row);
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("** fixed_partition_fit_allocator: PASSED **");
      end else begin
         $display("** fixed_partition_fit_allocator: FAILED **");
      end
      $finish;
   end

   // Receiver: stall pattern of its own, plus the long hold-off on request
   initial begin
      int holdoff_left;
      int holdoff_served;
      int mode;
      int mode_left;
      int tick;
      holdoff_left   = 0;
      holdoff_served = 0;
      mode           = 0;
      mode_left      = 64;
      tick           = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
         end else if (holdoff_served != holdoff_asked) begin
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            tick++;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (tick % 3 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Check each response beat against the oldest awaited one
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with none awaited, status", rsp_bus.status, 0);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.granted_partition !== want.part)
               report_mismatch("granted_partition", rsp_bus.granted_partition, want.part);
            if (rsp_bus.waste !== want.waste)
               report_mismatch("waste", rsp_bus.waste, want.waste);
         end
      end
   end

   // Count cycles in which no beat moves on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("** fixed_partition_fit_allocator: FAILED **");
      $finish;
   end

endmodule
